// ===== rtl/tvdi_pkg.sv =====
// Package for the tolerant vertex dedup indexer: sizes of the vertex table,
// field widths and the per-component tolerance compare. Depends on nothing.
package tvdi_pkg;

   localparam int MaxVertices = 4096;
   localparam int NumComponents = 8;
   localparam int CompWidth = 32;
   localparam int TolWidth = 16;
   localparam int IndexWidth = 12;
   localparam int CountWidth = $clog2(MaxVertices + 1);
   localparam int AddrWidth = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
   localparam int VertexWidth = NumComponents * CompWidth;
   localparam logic [TolWidth-1:0] ResetTolerance = TolWidth'(655);

   typedef logic [VertexWidth-1:0] vertex_type;

   function automatic logic comp_close(input logic [CompWidth-1:0] a,
                                       input logic [CompWidth-1:0] b,
                                       input logic [TolWidth-1:0] tol);
      logic signed [CompWidth:0] diff;
      logic [CompWidth:0] mag;
      diff = $signed({a[CompWidth-1], a}) - $signed({b[CompWidth-1], b});
      mag = diff[CompWidth] ? (CompWidth+1)'(-diff) : (CompWidth+1)'(diff);
      return mag < {{(CompWidth+1-TolWidth){1'b0}}, tol};
   endfunction

   function automatic logic vertex_close(input vertex_type a,
                                         input vertex_type b,
                                         input logic [TolWidth-1:0] tol);
      logic all_close;
      all_close = 1'b1;
      for (int c = 0; c < NumComponents; c++) begin
         all_close = all_close & comp_close(a[c*CompWidth +: CompWidth],
                                            b[c*CompWidth +: CompWidth], tol);
      end
      return all_close;
   endfunction

endpackage

// ===== rtl/tolerant_vertex_dedup_indexer_top.sv =====
// Top level of the tolerant vertex dedup indexer: vertex table memory,
// scan sequencer and result register. Depends on tvdi_pkg.
//
// Usage: one vertex item enters on the req_ channel (accepted when req_valid
// is high and req_stall low) and exactly one result item leaves on the rsp_
// channel. The item is compared against the stored unique vertices in
// insertion order, one table entry per cycle through the memory read port,
// so a hit on entry k ends the scan there and a miss reads every stored
// entry. One item is in the scan at a time. A miss appends the vertex in
// the cycle the result is loaded; a miss on a full table stores nothing
// and reports table_full. start_mesh empties the table before its own
// vertex. The result register holds an item while rsp_stall is high; the
// next vertex may be accepted and scanned meanwhile, and only its final
// step waits for the register to free up. The user must write the
// tolerance register on the csr_ channel only while the block is idle;
// the block does not enforce this. Reset empties the table at once (no
// clearing pass) and loads the tolerance of about 0.01.
module tolerant_vertex_dedup_indexer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_start_mesh,
   input  logic [tvdi_pkg::CompWidth-1:0] req_pos_x,
   input  logic [tvdi_pkg::CompWidth-1:0] req_pos_y,
   input  logic [tvdi_pkg::CompWidth-1:0] req_pos_z,
   input  logic [tvdi_pkg::CompWidth-1:0] req_tex_u,
   input  logic [tvdi_pkg::CompWidth-1:0] req_tex_v,
   input  logic [tvdi_pkg::CompWidth-1:0] req_nrm_x,
   input  logic [tvdi_pkg::CompWidth-1:0] req_nrm_y,
   input  logic [tvdi_pkg::CompWidth-1:0] req_nrm_z,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tvdi_pkg::IndexWidth-1:0] rsp_vtx_index,
   output logic                           rsp_is_new,
   output logic                           rsp_table_full,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tvdi_pkg::TolWidth-1:0]  csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                          state_ff, state_in;
   logic [tvdi_pkg::CountWidth-1:0]    count_ff, count_in;
   logic [tvdi_pkg::CountWidth-1:0]    rd_addr_ff, rd_addr_in;
   logic [tvdi_pkg::CountWidth-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                               cmp_valid_ff, cmp_valid_in;
   logic                               hit_ff, hit_in;
   logic [tvdi_pkg::CountWidth-1:0]    hit_idx_ff, hit_idx_in;
   logic [tvdi_pkg::TolWidth-1:0]      tol_ff, tol_in;
   tvdi_pkg::vertex_type               vtx_ff, vtx_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [tvdi_pkg::IndexWidth-1:0]    rsp_index_ff, rsp_index_in;
   logic                               rsp_new_ff, rsp_new_in;
   logic                               rsp_full_ff, rsp_full_in;

   tvdi_pkg::vertex_type               mem [tvdi_pkg::MaxVertices];
   tvdi_pkg::vertex_type               rd_data_ff;
   logic                               rd_en, wr_en, accept, finish, table_full;
   logic                               entry_hit;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept = req_valid && !req_stall;
   assign rd_en = (state_ff == ST_SCAN) && (rd_addr_ff < count_ff) && !entry_hit;
   assign finish = (state_ff == ST_FINISH) && !(rsp_valid_ff && rsp_stall);
   assign table_full = (count_ff >= tvdi_pkg::CountWidth'(tvdi_pkg::MaxVertices));
   assign wr_en = finish && !hit_ff && !table_full;
   assign entry_hit = cmp_valid_ff && tvdi_pkg::vertex_close(vtx_ff, rd_data_ff, tol_ff);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr_ff[tvdi_pkg::AddrWidth-1:0]];
      end
      if (wr_en) begin
         mem[count_ff[tvdi_pkg::AddrWidth-1:0]] <= vtx_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rd_addr_in = rd_addr_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_valid_in = 1'b0;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      tol_in = tol_ff;
      vtx_in = vtx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_new_in = rsp_new_ff;
      rsp_full_in = rsp_full_ff;
      if (csr_valid && csr_ready) begin
         tol_in = csr_data;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_start_mesh) begin
                  count_in = '0;
               end
               vtx_in = {req_nrm_z, req_nrm_y, req_nrm_x, req_tex_v,
                         req_tex_u, req_pos_z, req_pos_y, req_pos_x};
               rd_addr_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (entry_hit) begin
               hit_in = 1'b1;
               hit_idx_in = cmp_idx_ff;
               state_in = ST_FINISH;
            end else if (rd_en) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in = rd_addr_ff;
               rd_addr_in = rd_addr_ff + 1'b1;
            end else if (!cmp_valid_ff) begin
               hit_in = 1'b0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               if (hit_ff) begin
                  rsp_index_in = hit_idx_ff[tvdi_pkg::IndexWidth-1:0];
                  rsp_new_in = 1'b0;
                  rsp_full_in = 1'b0;
               end else if (table_full) begin
                  rsp_index_in = '0;
                  rsp_new_in = 1'b0;
                  rsp_full_in = 1'b1;
               end else begin
                  rsp_index_in = count_ff[tvdi_pkg::IndexWidth-1:0];
                  rsp_new_in = 1'b1;
                  rsp_full_in = 1'b0;
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         cmp_valid_ff <= 1'b0;
         tol_ff <= tvdi_pkg::ResetTolerance;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         tol_ff <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_addr_ff <= rd_addr_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_ff <= hit_in;
      hit_idx_ff <= hit_idx_in;
      vtx_ff <= vtx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_new_ff <= rsp_new_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_vtx_index = rsp_index_ff;
   assign rsp_is_new = rsp_new_ff;
   assign rsp_table_full = rsp_full_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tvdi_pkg::CountWidth'(tvdi_pkg::MaxVertices))
      else $error("Entry count exceeds the table depth.");

   a_scan_below_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rd_addr_ff <= count_ff))
      else $error("Scan address ran past the entry count.");

   a_compare_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && cmp_valid_ff) |-> (cmp_idx_ff < count_ff))
      else $error("Compared an entry at or above the entry count.");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (count_ff == $past(count_ff) + 1'b1) && rsp_valid && rsp_is_new)
      else $error("Append did not advance the entry count.");

endmodule

// ===== verif/vertex_index_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the tolerant vertex dedup indexer: watches the vertex, result and
// tolerance channels, predicts the index of each vertex and compares every result item.
// Depends on tvdi_pkg for widths and the table size.
module dedup_result_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_start_mesh,
   input  logic [tvdi_pkg::CompWidth-1:0]  req_pos_x,
   input  logic [tvdi_pkg::CompWidth-1:0]  req_pos_y,
   input  logic [tvdi_pkg::CompWidth-1:0]  req_pos_z,
   input  logic [tvdi_pkg::CompWidth-1:0]  req_tex_u,
   input  logic [tvdi_pkg::CompWidth-1:0]  req_tex_v,
   input  logic [tvdi_pkg::CompWidth-1:0]  req_nrm_x,
   input  logic [tvdi_pkg::CompWidth-1:0]  req_nrm_y,
   input  logic [tvdi_pkg::CompWidth-1:0]  req_nrm_z,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [tvdi_pkg::IndexWidth-1:0] rsp_vtx_index,
   input  logic                            rsp_is_new,
   input  logic                            rsp_table_full,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [tvdi_pkg::TolWidth-1:0]   csr_data,
   output int                              mismatch_count,
   output int                              pending_count
);

   typedef struct packed {
      logic [tvdi_pkg::IndexWidth-1:0] idx;
      logic                            is_new;
      logic                            table_full;
   } index_result_type;

   tvdi_pkg::vertex_type unique_vertices [tvdi_pkg::MaxVertices];
   int                   stored_count;
   int                   tolerance;
   int                   fail_total;
   index_result_type     pending_results [$];

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch at %0t: %s is %0h, expected %0h", $time, what, got, want);
      fail_total++;
   endtask

   // Linear first-match search in insertion order; a miss appends while there is room.
   function automatic index_result_type predict_result(input logic start,
                                                       input tvdi_pkg::vertex_type v);
      index_result_type r;
      int               hit_at;
      bit               all_close;
      longint           d;
      if (start) begin
         stored_count = 0;
      end
      hit_at = -1;
      // A strict compare against a zero limit can never succeed.
      if (tolerance != 0) begin
         for (int i = 0; i < stored_count && hit_at < 0; i++) begin
            all_close = 1'b1;
            for (int c = 0; c < tvdi_pkg::NumComponents; c++) begin
               d = longint'($signed(v[c*tvdi_pkg::CompWidth +: tvdi_pkg::CompWidth])) -
                   longint'($signed(
                      unique_vertices[i][c*tvdi_pkg::CompWidth +: tvdi_pkg::CompWidth]));
               if (d < 0) begin
                  d = -d;
               end
               if (d >= tolerance) begin
                  all_close = 1'b0;
               end
            end
            if (all_close) begin
               hit_at = i;
            end
         end
      end
      if (hit_at >= 0) begin
         r.idx = tvdi_pkg::IndexWidth'(hit_at);
         r.is_new = 1'b0;
         r.table_full = 1'b0;
      end else if (stored_count >= tvdi_pkg::MaxVertices) begin
         r.idx = '0;
         r.is_new = 1'b0;
         r.table_full = 1'b1;
      end else begin
         unique_vertices[stored_count] = v;
         r.idx = tvdi_pkg::IndexWidth'(stored_count);
         r.is_new = 1'b1;
         r.table_full = 1'b0;
         stored_count++;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      index_result_type want;
      if (reset) begin
         tolerance = int'(tvdi_pkg::ResetTolerance);
         stored_count = 0;
         pending_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with no vertex pending, vtx_index",
                               16'(rsp_vtx_index), 'x);
            end else begin
               want = pending_results.pop_front();
               if (rsp_vtx_index !== want.idx) begin
                  report_mismatch("vtx_index", 16'(rsp_vtx_index), 16'(want.idx));
               end
               if (rsp_is_new !== want.is_new) begin
                  report_mismatch("is_new", 16'(rsp_is_new), 16'(want.is_new));
               end
               if (rsp_table_full !== want.table_full) begin
                  report_mismatch("table_full", 16'(rsp_table_full),
                                  16'(want.table_full));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            tolerance = int'(csr_data);
         end
         if (req_valid && !req_stall) begin
            pending_results.insert(pending_results.size(), predict_result(req_start_mesh,
               {req_nrm_z, req_nrm_y, req_nrm_x, req_tex_v, req_tex_u,
                req_pos_z, req_pos_y, req_pos_x}));
         end
      end
      mismatch_count <= fail_total;
      pending_count <= pending_results.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for the tolerant vertex dedup indexer: drives vertex items, tolerance
// writes and result stalls, and gives the verdict. Depends on tvdi_pkg, the block and
// dedup_result_checker.
module testbench;
   localparam int CW = tvdi_pkg::CompWidth;
   localparam int NC = tvdi_pkg::NumComponents;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_start_mesh = 1'b0;
   logic [CW-1:0]                   req_pos_x = '0;
   logic [CW-1:0]                   req_pos_y = '0;
   logic [CW-1:0]                   req_pos_z = '0;
   logic [CW-1:0]                   req_tex_u = '0;
   logic [CW-1:0]                   req_tex_v = '0;
   logic [CW-1:0]                   req_nrm_x = '0;
   logic [CW-1:0]                   req_nrm_y = '0;
   logic [CW-1:0]                   req_nrm_z = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [tvdi_pkg::IndexWidth-1:0] rsp_vtx_index;
   logic                            rsp_is_new;
   logic                            rsp_table_full;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [tvdi_pkg::TolWidth-1:0]   csr_data = '0;

   int                   mismatch_count;
   int                   pending_count;
   bit                   idling_on = 1'b1;
   int                   cur_tol = int'(tvdi_pkg::ResetTolerance);
   int                   stall_left = 0;
   tvdi_pkg::vertex_type vertex_pool [$];

   tolerant_vertex_dedup_indexer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_mesh   (req_start_mesh),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_tex_u        (req_tex_u),
      .req_tex_v        (req_tex_v),
      .req_nrm_x        (req_nrm_x),
      .req_nrm_y        (req_nrm_y),
      .req_nrm_z        (req_nrm_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vtx_index    (rsp_vtx_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_table_full   (rsp_table_full),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   dedup_result_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_mesh   (req_start_mesh),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_tex_u        (req_tex_u),
      .req_tex_v        (req_tex_v),
      .req_nrm_x        (req_nrm_x),
      .req_nrm_y        (req_nrm_y),
      .req_nrm_z        (req_nrm_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vtx_index    (rsp_vtx_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_table_full   (rsp_table_full),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 80);
   endfunction

   function automatic tvdi_pkg::vertex_type splat(input logic [CW-1:0] value);
      return {NC{value}};
   endfunction

   function automatic tvdi_pkg::vertex_type make_fresh();
      tvdi_pkg::vertex_type v;
      bit                   near_origin;
      near_origin = ($urandom_range(0, 2) == 0);
      for (int c = 0; c < NC; c++) begin
         v[c*CW +: CW] = near_origin ? CW'(int'($urandom_range(0, 4000)) - 2000) : $urandom;
      end
      return v;
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (idling_on) begin
            stall_left = pick_gap();
         end
      end
   end

   task automatic send_vertex(input logic start, input tvdi_pkg::vertex_type v);
      int gap;
      req_valid <= 1'b1;
      req_start_mesh <= start;
      req_pos_x <= v[0*CW +: CW];
      req_pos_y <= v[1*CW +: CW];
      req_pos_z <= v[2*CW +: CW];
      req_tex_u <= v[3*CW +: CW];
      req_tex_v <= v[4*CW +: CW];
      req_nrm_x <= v[5*CW +: CW];
      req_nrm_y <= v[6*CW +: CW];
      req_nrm_z <= v[7*CW +: CW];
      do @(posedge clock); while (req_stall);
      if (start) begin
         vertex_pool.delete();
      end
      vertex_pool.insert(vertex_pool.size(), v);
      gap = idling_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_tolerance(input logic [tvdi_pkg::TolWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_tol = int'(value);
   endtask

   // Mostly near copies of earlier vertices of the same mesh, so that hits, first-match
   // order and misses by one component at the limit all occur.
   task automatic run_random_phase(input int count, input bit pause_midway);
      tvdi_pkg::vertex_type v;
      logic                 start;
      int                   pick;
      int                   d;
      int                   spoil;
      for (int n = 0; n < count; n++) begin
         start = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 99) < 65 && vertex_pool.size() > 0) begin
            v = vertex_pool[$urandom_range(0, vertex_pool.size() - 1)];
            spoil = ($urandom_range(0, 99) < 40) ? $urandom_range(0, NC - 1) : -1;
            for (int c = 0; c < NC; c++) begin
               pick = $urandom_range(0, 9);
               if (c == spoil) begin
                  if (pick < 7) begin
                     d = ($urandom_range(0, 1) ? 1 : -1) * (cur_tol + $urandom_range(0, 2));
                  end else begin
                     d = int'($urandom);
                  end
               end else if (cur_tol == 0) begin
                  d = 0;
               end else if (pick < 8) begin
                  d = int'($urandom_range(0, 2 * cur_tol - 2)) - (cur_tol - 1);
               end else begin
                  d = ($urandom_range(0, 1) ? 1 : -1) * (cur_tol - 1);
               end
               v[c*CW +: CW] = v[c*CW +: CW] + CW'(d);
            end
         end else begin
            v = make_fresh();
         end
         send_vertex(start, v);
         if (pause_midway && n == count / 2) begin
            drain_results();
         end
      end
   endtask

   initial begin
      tvdi_pkg::vertex_type v;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_vertex(1'b1, splat(0));
      send_vertex(1'b0, splat(654));
      send_vertex(1'b0, splat(-655));
      v = splat(0);
      v[0 +: CW] = 32'h7FFF_FFFF;
      send_vertex(1'b0, v);
      v[0 +: CW] = 32'h8000_0000;
      send_vertex(1'b0, v);
      send_vertex(1'b0, splat(32'h7FFF_FFFF));
      send_vertex(1'b0, splat(32'h8000_0000));
      send_vertex(1'b0, splat(32'h7FFF_FD71));
      send_vertex(1'b1, splat(0));
      send_vertex(1'b0, splat(0));
      drain_results();
      write_tolerance(16'hFFFF);
      send_vertex(1'b0, splat(65534));
      send_vertex(1'b0, splat(-65535));
      send_vertex(1'b0, splat(-1));
      v = splat(0);
      v[7*CW +: CW] = 65535;
      send_vertex(1'b0, v);
      drain_results();
      write_tolerance(16'd1);
      send_vertex(1'b0, splat(0));
      send_vertex(1'b0, splat(1));
      send_vertex(1'b0, splat(-1));

      drain_results();
      write_tolerance(16'($urandom_range(2, 2000)));
      run_random_phase(25, 1'b0);
      drain_results();
      write_tolerance(16'hFFFF);
      run_random_phase(25, 1'b1);
      drain_results();
      idling_on = 1'b0;
      write_tolerance(16'($urandom_range(0, 65535)));
      run_random_phase(20, 1'b0);
      drain_results();
      idling_on = 1'b1;
      write_tolerance(16'd1);
      run_random_phase(20, 1'b0);
      drain_results();
      write_tolerance(tvdi_pkg::ResetTolerance);
      run_random_phase(30, 1'b1);

      // With a zero limit every vertex misses, even an exact repeat.
      drain_results();
      write_tolerance(16'd0);
      send_vertex(1'b0, splat(0));
      send_vertex(1'b0, splat(0));
      drain_results();
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tvdi_pkg.sv
rtl/tolerant_vertex_dedup_indexer_top.sv
verif/vertex_index_checker.sv
verif/testbench.sv
